[src/text_column_extractor_defines.svh]
// ----------------------------------------------------------------------------
// text column extractor assertion macros
// concurrent checks clocked on clock and quiet while reset is high
// ----------------------------------------------------------------------------
`ifndef TEXT_COLUMN_EXTRACTOR_DEFINES_SVH
`define TEXT_COLUMN_EXTRACTOR_DEFINES_SVH

// condition must hold at every edge
`define TCE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define TCE_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/tce_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tce_pkg
// types, codes and per-byte helper functions of the text column extractor
// ----------------------------------------------------------------------------
package tce_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_BYTE       = 2'd0,
      KIND_EOL        = 2'd1,
      KIND_NO_COLUMN  = 2'd2,
      KIND_SHORT_FILE = 2'd3
   } tce_kind_type;

   // register indexes
   localparam logic [1:0] CSR_COLUMN_INDEX = 2'd0;
   localparam logic [1:0] CSR_SKIP_LINES   = 2'd1;
   localparam logic [1:0] CSR_FILTER_MODE  = 2'd2;

   // filter modes
   localparam logic [1:0] FILTER_NONE = 2'd0;
   localparam logic [1:0] FILTER_ES   = 2'd1;
   localparam logic [1:0] FILTER_SEMI = 2'd2;

   // characters
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_S     = 8'h73;

   localparam logic [7:0]  COLUMNS_MAX = 8'hFF;
   localparam logic [15:0] LINES_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  column_index;
      logic [15:0] skip_lines;
      logic [1:0]  filter_mode;
   } tce_cfg_type;

   // word tracking within one line
   typedef struct packed {
      logic [7:0] columns_passed;
      logic       line_has_text;
      logic       inside_word;
      logic       column_finished;
   } tce_word_type;

   typedef struct packed {
      tce_word_type word;
      logic         emit;
   } tce_feed_type;

   typedef struct packed {
      tce_kind_type kind;
      logic [7:0]   data;
   } tce_entry_type;

   // results of one byte, core to result buffer
   typedef struct packed {
      logic                load;
      logic [1:0]          count;
      tce_entry_type [2:0] entry;
   } tce_result_type;

   function automatic logic tce_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   // advance word tracking by one byte of a kept line
   function automatic tce_feed_type tce_feed(input tce_word_type w, input logic [7:0] b,
                                             input logic [7:0] col);
      tce_feed_type r;
      r.word = w;
      r.emit = 1'b0;
      if (tce_blank(b)) begin
         if (w.inside_word) begin
            r.word.inside_word = 1'b0;
            if (w.columns_passed == col) begin
               r.word.column_finished = 1'b1;
            end else if (w.columns_passed < COLUMNS_MAX) begin
               r.word.columns_passed = w.columns_passed + 8'd1;
            end
         end
      end else begin
         r.word.line_has_text = 1'b1;
         r.word.inside_word   = 1'b1;
         r.emit = !w.column_finished && (w.columns_passed == col);
      end
      return r;
   endfunction

endpackage

[src/tce_core.sv]
`timescale 1ns / 1ps
`include "text_column_extractor_defines.svh"
// ----------------------------------------------------------------------------
// tce_core
// input register, line and column state, and the per-byte result logic
// ----------------------------------------------------------------------------
module tce_core (
   input  logic                   clock,
   input  logic                   reset,
   input  tce_pkg::tce_cfg_type   cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   input  logic                   in_end,
   input  logic                   buf_free,
   output tce_pkg::tce_result_type result
);
   import tce_pkg::*;

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_end_ff;
   logic         process;

   logic [15:0]  lines_skipped_ff, lines_skipped_in;
   logic         skipping_done_ff, skipping_done_in;
   logic         at_line_start_ff, at_line_start_in;
   tce_word_type word_ff, word_in;
   logic         line_dropped_ff, line_dropped_in;
   logic [7:0]   held_byte_ff, held_byte_in;
   logic         held_valid_ff, held_valid_in;
   logic         halted_ff, halted_in;

   assign process  = in_valid_ff && buf_free;
   assign in_ready = !in_valid_ff || buf_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_byte_ff <= in_byte;
         in_end_ff  <= in_end;
      end
   end

   always_comb begin
      logic         eol;
      logic         go_on;
      logic         reached;
      logic [1:0]   n;
      tce_feed_type fr;

      lines_skipped_in = lines_skipped_ff;
      skipping_done_in = skipping_done_ff;
      at_line_start_in = at_line_start_ff;
      word_in          = word_ff;
      line_dropped_in  = line_dropped_ff;
      held_byte_in     = held_byte_ff;
      held_valid_in    = held_valid_ff;
      halted_in        = halted_ff;
      result           = '0;
      n                = 2'd0;
      go_on            = 1'b1;
      reached          = 1'b0;
      fr               = '0;
      eol              = (in_byte_ff == CHAR_LF) || in_end_ff;

      if (process && !halted_ff) begin
         if (at_line_start_ff) begin
            if (!skipping_done_in && (lines_skipped_in >= cfg.skip_lines)) begin
               skipping_done_in = 1'b1;
            end
            word_in          = '0;
            line_dropped_in  = 1'b0;
            held_valid_in    = 1'b0;
            at_line_start_in = 1'b0;
            if (skipping_done_in) begin
               if (((cfg.filter_mode == FILTER_ES) || (cfg.filter_mode == FILTER_SEMI)) &&
                   (in_byte_ff == CHAR_SEMI)) begin
                  line_dropped_in = 1'b1;
               end else if ((cfg.filter_mode == FILTER_ES) &&
                            ((in_byte_ff == CHAR_E) || (in_byte_ff == CHAR_S))) begin
                  if (in_end_ff) begin
                     line_dropped_in = 1'b1;
                  end else begin
                     // hold a possible lone e or s until the next byte
                     held_byte_in  = in_byte_ff;
                     held_valid_in = 1'b1;
                     go_on         = 1'b0;
                  end
               end
            end
         end else if (held_valid_ff) begin
            held_valid_in = 1'b0;
            if (in_byte_ff == CHAR_LF) begin
               line_dropped_in = 1'b1;
            end else begin
               fr      = tce_feed(word_in, held_byte_ff, cfg.column_index);
               word_in = fr.word;
               if (fr.emit) begin
                  result.entry[n] = '{kind: KIND_BYTE, data: held_byte_ff};
                  n = n + 2'd1;
               end
            end
         end

         if (go_on) begin
            if (!skipping_done_in) begin
               if (!tce_blank(in_byte_ff)) begin
                  word_in.line_has_text = 1'b1;
               end
               if (eol) begin
                  if (word_in.line_has_text && (lines_skipped_in < LINES_MAX)) begin
                     lines_skipped_in = lines_skipped_in + 16'd1;
                  end
                  at_line_start_in = 1'b1;
                  if (in_end_ff) begin
                     if (lines_skipped_in < cfg.skip_lines) begin
                        result.entry[n] = '{kind: KIND_SHORT_FILE, data: 8'h00};
                        n = n + 2'd1;
                        halted_in = 1'b1;
                     end else begin
                        lines_skipped_in = '0;
                        skipping_done_in = (cfg.skip_lines == '0);
                        held_valid_in    = 1'b0;
                     end
                  end
               end
            end else begin
               if (!line_dropped_in) begin
                  fr      = tce_feed(word_in, in_byte_ff, cfg.column_index);
                  word_in = fr.word;
                  if (fr.emit) begin
                     result.entry[n] = '{kind: KIND_BYTE, data: in_byte_ff};
                     n = n + 2'd1;
                  end
               end
               if (eol) begin
                  if (!line_dropped_in) begin
                     reached = word_in.column_finished ||
                               (word_in.inside_word &&
                                (word_in.columns_passed == cfg.column_index));
                     if (!word_in.line_has_text || reached) begin
                        result.entry[n] = '{kind: KIND_EOL, data: 8'h00};
                     end else begin
                        result.entry[n] = '{kind: KIND_NO_COLUMN, data: 8'h00};
                        halted_in = 1'b1;
                     end
                     n = n + 2'd1;
                  end
                  at_line_start_in = 1'b1;
                  if (in_end_ff && !halted_in) begin
                     lines_skipped_in = '0;
                     skipping_done_in = (cfg.skip_lines == '0);
                     held_valid_in    = 1'b0;
                  end
               end
            end
         end
      end

      result.count = n;
      result.load  = process && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lines_skipped_ff <= '0;
         skipping_done_ff <= 1'b1;
         at_line_start_ff <= 1'b1;
         word_ff          <= '0;
         line_dropped_ff  <= 1'b0;
         held_valid_ff    <= 1'b0;
         halted_ff        <= 1'b0;
      end else if (process) begin
         lines_skipped_ff <= lines_skipped_in;
         skipping_done_ff <= skipping_done_in;
         at_line_start_ff <= at_line_start_in;
         word_ff          <= word_in;
         line_dropped_ff  <= line_dropped_in;
         held_valid_ff    <= held_valid_in;
         halted_ff        <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         held_byte_ff <= held_byte_in;
      end
   end

   `TCE_ASSERT_NEXT(a_halt_sticky, halted_ff, halted_ff, "halt released without reset")
   `TCE_ASSERT_IMPLY(a_halt_silent, process && halted_ff, !result.load,
                     "result produced while halted")
   `TCE_ASSERT_IMPLY(a_held_mid_line, held_valid_ff, !at_line_start_ff && skipping_done_ff,
                     "held byte outside a started line")

endmodule

[src/tce_rsp_buffer.sv]
`timescale 1ns / 1ps
`include "text_column_extractor_defines.svh"
// ----------------------------------------------------------------------------
// tce_rsp_buffer
// holds the up to three results of one byte and hands them out one a cycle while rsp_tready is high
// ----------------------------------------------------------------------------
module tce_rsp_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  tce_pkg::tce_result_type result,
   output logic                   buf_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tlast
);
   import tce_pkg::*;

   tce_entry_type [2:0] entry_ff;
   logic [1:0]          count_ff, count_in;
   logic [1:0]          ptr_ff, ptr_in;
   logic                last;
   logic                drain;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign last       = (2'(ptr_ff + 2'd1) == count_ff);
   assign drain      = rsp_tvalid && rsp_tready;
   assign buf_free   = !rsp_tvalid || (drain && last);

   assign rsp_tdata = entry_ff[ptr_ff].data;
   assign rsp_tuser = entry_ff[ptr_ff].kind;
   assign rsp_tlast = last;

   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (result.load) begin
         count_in = result.count;
         ptr_in   = 2'd0;
      end else if (drain) begin
         if (last) begin
            count_in = 2'd0;
            ptr_in   = 2'd0;
         end else begin
            ptr_in = ptr_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         ptr_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         entry_ff <= result.entry;
      end
   end

   `TCE_ASSERT_IMPLY(a_load_when_free, result.load, buf_free,
                     "results loaded over pending transactions")
   `TCE_ASSERT_IMPLY(a_ptr_in_range, rsp_tvalid, ptr_ff < count_ff,
                     "read pointer beyond stored results")
   `TCE_ASSERT_NEXT(a_stall_holds, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(ptr_ff) && $stable(count_ff),
                    "pending result moved during stall")

endmodule

[src/text_column_extractor.sv]
`timescale 1ns / 1ps
// Text column extractor. Takes a text file one byte per req transaction (req_tlast marks
// the final byte) and returns the chosen whitespace-separated column of each line followed
// by an end-of-line result, after dropping skip_lines non-blank lines at the file start.
// Bytes pass through an input register, are resolved combinationally against the line
// state, and their results land in a three-entry result buffer that drains one per cycle
// while rsp_tready is high, so text with at most one result per byte streams at one byte
// per clock, while a byte with two or three results holds the input until the single
// result port has sent them all. A byte's results are offered once loaded into the result
// buffer. After a missing-column or short-file error the block keeps taking bytes but
// returns nothing until reset. Configuration writes take effect at once and are meant for
// an idle block; skip_lines is compared at each line start, so a change while lines are
// still being skipped counts from the next line, and otherwise from the next file.
// ----------------------------------------------------------------------------
// text_column_extractor
// top level: configuration registers, core and result buffer
// ----------------------------------------------------------------------------
module text_column_extractor (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // file_end
   // responses
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // run_last
);
   import tce_pkg::*;

   tce_cfg_type    cfg_ff;
   tce_result_type result;
   logic           buf_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMN_INDEX: cfg_ff.column_index <= csr_data[7:0];
            CSR_SKIP_LINES:   cfg_ff.skip_lines   <= csr_data;
            CSR_FILTER_MODE:  cfg_ff.filter_mode  <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   tce_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tlast),
      .buf_free (buf_free),
      .result   (result)
   );

   tce_rsp_buffer u_rsp_buffer (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .buf_free   (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[dv/text_column_extractor_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_column_extractor_test
// streams generated text files through the column extractor and compares
// every result transaction with a predictor of its own, over phases with
// different column, skip and filter settings and one closing error
// ----------------------------------------------------------------------------
module text_column_extractor_test;
   import tce_pkg::*;

   localparam int CLOCK_HIGH       = 6;
   localparam int CLOCK_LOW        = 6;
   localparam int RESET_CYCLES     = 8;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int RANDOM_BYTES     = 120;
   localparam int TIMEOUT_CYCLES   = 300000;

   localparam logic [7:0] CHAR_VT = 8'h0B;
   localparam logic [7:0] CHAR_FF = 8'h0C;

   // how the first byte of a generated word line is chosen
   localparam int FIRST_ANY  = 0;
   localparam int FIRST_SEMI = 1;
   localparam int FIRST_ES   = 2;

   typedef struct packed {
      logic [7:0] text;
      logic       file_end;
   } text_item_type;

   typedef struct packed {
      tce_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } column_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] text_byte
   logic        req_tlast = 1'b0;   // file_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] out_byte
   logic [1:0]  rsp_tuser;          // [1:0] kind
   logic        rsp_tlast;          // run_last

   text_column_extractor i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #CLOCK_HIGH clock = 1'b1;
      #CLOCK_LOW  clock = 1'b0;
   end

   // stimulus and scoreboard
   text_item_type     text_bytes[$];
   column_result_type column_results[$];
   logic [7:0]        line_buf[$];

   int bytes_queued  = 0;
   int bytes_taken   = 0;
   int files_sent    = 0;
   int csr_writes    = 0;
   int results_seen  = 0;
   int error_count   = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int send_gap      = 0;
   int stall_left    = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   bit quiet         = 1'b0;
   bit gen_skip_done = 1'b1;

   // predictor copy of configuration and line state
   logic [7:0]  cfg_column = 8'd0;
   logic [15:0] cfg_skip   = 16'd0;
   logic [1:0]  cfg_filter = FILTER_NONE;

   logic [15:0] lines_skipped   = 16'd0;
   logic [7:0]  columns_passed  = 8'd0;
   logic [7:0]  held_byte       = 8'd0;
   logic        skipping_done   = 1'b1;
   logic        at_line_start   = 1'b1;
   logic        line_has_text   = 1'b0;
   logic        inside_word     = 1'b0;
   logic        column_finished = 1'b0;
   logic        line_dropped    = 1'b0;
   logic        held_valid      = 1'b0;
   logic        halted          = 1'b0;

   column_result_type step_out[3];
   int                step_count;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
   endfunction

   task automatic add_result(input tce_kind_type kind, input logic [7:0] data);
      if (step_count < 3) begin
         step_out[step_count] = '{kind, data, 1'b0};
         step_count++;
      end
   endtask

   task automatic start_file();
      lines_skipped = 16'd0;
      skipping_done = (cfg_skip == 16'd0);
      at_line_start = 1'b1;
      held_valid    = 1'b0;
   endtask

   task automatic feed_word(input logic [7:0] b);
      if (is_blank(b)) begin
         if (inside_word) begin
            inside_word = 1'b0;
            if (columns_passed == cfg_column) begin
               column_finished = 1'b1;
            end else if (columns_passed < COLUMNS_MAX) begin
               columns_passed++;
            end
         end
      end else begin
         line_has_text = 1'b1;
         inside_word   = 1'b1;
         if (!column_finished && columns_passed == cfg_column) add_result(KIND_BYTE, b);
      end
   endtask

   task automatic extract_column_step(input logic [7:0] b, input logic fe);
      logic              eol;
      logic              reached;
      column_result_type r;
      eol = (b == CHAR_LF) || fe;
      step_count = 0;
      if (halted) return;
      if (at_line_start) begin
         if (!skipping_done && lines_skipped >= cfg_skip) skipping_done = 1'b1;
         line_has_text   = 1'b0;
         columns_passed  = 8'd0;
         inside_word     = 1'b0;
         column_finished = 1'b0;
         line_dropped    = 1'b0;
         held_valid      = 1'b0;
         at_line_start   = 1'b0;
         if (skipping_done) begin
            if ((cfg_filter == FILTER_ES || cfg_filter == FILTER_SEMI) && b == CHAR_SEMI) begin
               line_dropped = 1'b1;
            end else if (cfg_filter == FILTER_ES && (b == CHAR_E || b == CHAR_S)) begin
               if (fe) begin
                  line_dropped = 1'b1;
               end else begin
                  // wait for the next byte to tell a lone e or s line
                  held_byte  = b;
                  held_valid = 1'b1;
                  return;
               end
            end
         end
      end else if (held_valid) begin
         held_valid = 1'b0;
         if (b == CHAR_LF) line_dropped = 1'b1;
         else feed_word(held_byte);
      end

      if (!skipping_done) begin
         if (!is_blank(b)) line_has_text = 1'b1;
         if (eol) begin
            if (line_has_text && lines_skipped < LINES_MAX) lines_skipped++;
            at_line_start = 1'b1;
            if (fe) begin
               if (lines_skipped < cfg_skip) begin
                  add_result(KIND_SHORT_FILE, 8'd0);
                  halted = 1'b1;
               end else begin
                  start_file();
               end
            end
         end
      end else begin
         if (!line_dropped) feed_word(b);
         if (eol) begin
            if (!line_dropped) begin
               reached = column_finished || (inside_word && columns_passed == cfg_column);
               if (!line_has_text || reached) begin
                  add_result(KIND_EOL, 8'd0);
               end else begin
                  add_result(KIND_NO_COLUMN, 8'd0);
                  halted = 1'b1;
               end
            end
            at_line_start = 1'b1;
            if (fe && !halted) start_file();
         end
      end

      for (int i = 0; i < step_count; i++) begin
         r = step_out[i];
         r.last = (i == step_count - 1);
         column_results.push_back(r);
      end
   endtask

   // driver: offers queued bytes, predicts each accepted transaction
   always @(posedge clock) begin
      text_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            extract_column_step(req_tdata, req_tlast);
            bytes_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 && !quiet) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (text_bytes.size() > 0) begin
               next_item = text_bytes.pop_front();
               req_tdata  <= next_item.text;
               req_tlast  <= next_item.file_end;
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
                  send_gap = $urandom_range(1, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transaction against the oldest expectation
   always @(posedge clock) begin
      column_result_type exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (column_results.size() == 0) begin
               $error("result with nothing expected: kind %0d out_byte %0h run_last %0b",
                      rsp_tuser, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               exp = column_results.pop_front();
               if (rsp_tuser !== exp.kind) begin
                  $error("kind expected %0d actual %0d", exp.kind, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata !== exp.data) begin
                  $error("out_byte expected %0h actual %0h", exp.data, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== exp.last) begin
                  $error("run_last expected %0b actual %0b", exp.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (hold_served != hold_requests) begin
            // long hold-off so the result buffer fills and stalls the input
            hold_served = hold_requests;
            stall_left  = LONG_HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0 && !quiet) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(0, 11);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COLUMN_INDEX: cfg_column = data[7:0];
         CSR_SKIP_LINES:   cfg_skip   = data;
         CSR_FILTER_MODE:  cfg_filter = data[1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic wait_idle();
      while (bytes_taken != bytes_queued || column_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic fe);
      text_bytes.push_back('{b, fe});
      bytes_queued++;
      if (fe) files_sent++;
   endtask

   task automatic queue_string(input string s, input bit eof);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], eof && (i == s.len() - 1));
   endtask

   function automatic logic [7:0] blank_char();
      logic [7:0] v;
      case ($urandom_range(0, 4))
         0: v = CHAR_SPACE;
         1: v = CHAR_TAB;
         2: v = CHAR_VT;
         3: v = CHAR_FF;
         default: v = CHAR_CR;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] word_char();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (is_blank(v));
      return v;
   endfunction

   task automatic build_word_line(input int nwords, input int first);
      if (first == FIRST_ANY) repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
      for (int w = 0; w < nwords; w++) begin
         if (w > 0) repeat ($urandom_range(1, 3)) line_buf.push_back(blank_char());
         for (int c = 0; c < $urandom_range(1, 4); c++) begin
            if (w == 0 && c == 0 && first == FIRST_SEMI) line_buf.push_back(CHAR_SEMI);
            else if (w == 0 && c == 0 && first == FIRST_ES)
               line_buf.push_back($urandom_range(0, 1) ? CHAR_E : CHAR_S);
            else line_buf.push_back(word_char());
         end
      end
      repeat ($urandom_range(0, 2)) line_buf.push_back(blank_char());
   endtask

   task automatic build_blank_line();
      repeat ($urandom_range(0, 3)) line_buf.push_back(blank_char());
   endtask

   task automatic build_comment();
      logic [7:0] v;
      line_buf.push_back(CHAR_SEMI);
      repeat ($urandom_range(0, 5)) begin
         v = 8'($urandom_range(0, 255));
         if (v == CHAR_LF) v = CHAR_SPACE;
         line_buf.push_back(v);
      end
   endtask

   // the last line of a file either ends in a marked newline or is cut short
   task automatic flush_line(input bit eof);
      if (eof && line_buf.size() > 0 && $urandom_range(0, 1)) begin
         for (int i = 0; i < line_buf.size(); i++) begin
            queue_byte(line_buf[i], i == line_buf.size() - 1);
         end
      end else begin
         foreach (line_buf[i]) queue_byte(line_buf[i], 1'b0);
         queue_byte(CHAR_LF, eof);
      end
      line_buf.delete();
   endtask

   // a file that never reaches an error with the current settings
   task automatic gen_file(input int nlines);
      int eff_skip;
      int nonblank;
      int pick;
      eff_skip = gen_skip_done ? 0 : int'(cfg_skip);
      nonblank = 0;
      while (nonblank < eff_skip) begin
         pick = $urandom_range(0, 4);
         case (pick)
            0: build_blank_line();
            1: line_buf.push_back($urandom_range(0, 1) ? CHAR_E : CHAR_S);
            2: build_comment();
            default: build_word_line($urandom_range(1, 3), $urandom_range(0, 2));
         endcase
         if (pick != 0) nonblank++;
         flush_line(1'b0);
      end
      for (int i = 0; i < nlines; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            build_blank_line();
         end else if (pick == 2 && (cfg_filter == FILTER_ES || cfg_column == 8'd0)) begin
            line_buf.push_back($urandom_range(0, 1) ? CHAR_E : CHAR_S);
         end else if (pick == 3 && (cfg_filter == FILTER_ES || cfg_filter == FILTER_SEMI)) begin
            build_comment();
         end else begin
            build_word_line($urandom_range(int'(cfg_column) + 1, int'(cfg_column) + 3),
                            pick == 3 ? FIRST_SEMI : (pick == 4 ? FIRST_ES : FIRST_ANY));
         end
         flush_line(i == nlines - 1);
      end
      // skip state of the next file is fixed when this one ends
      gen_skip_done = (cfg_skip == 16'd0);
   endtask

   task automatic do_phase(input logic [7:0] col, input logic [15:0] skip,
                           input logic [1:0] mode, input int nfiles, input bit hold);
      logic [7:0]  junk_hi;
      logic [13:0] junk_mode;
      junk_hi   = 8'($urandom);
      junk_mode = 14'($urandom);
      write_csr(CSR_COLUMN_INDEX, {junk_hi, col});
      write_csr(CSR_SKIP_LINES, skip);
      write_csr(CSR_FILTER_MODE, {junk_mode, mode});
      repeat (nfiles) gen_file($urandom_range(1, 3));
      if (hold) hold_requests++;
      wait_idle();
   endtask

   function automatic int idle_pick();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 40;
      endcase
   endfunction

   initial begin
      int  random_start;
      int  phase_count;
      int  pick;
      bit  short_branch;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 20;
      recv_idle_pct = 20;

      // e/s and comment drops, blank line, column after a tab, held byte released
      write_csr(CSR_COLUMN_INDEX, 16'd1);
      write_csr(CSR_SKIP_LINES, 16'd0);
      write_csr(CSR_FILTER_MODE, {14'd0, FILTER_ES});
      queue_string("e\n", 1'b0);
      queue_string("; x\n", 1'b0);
      queue_string(" a\tb\n", 1'b0);
      queue_byte(CHAR_VT, 1'b0);
      queue_byte(CHAR_LF, 1'b0);
      queue_string("s ", 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      // only comment lines dropped, lone s ends the file
      write_csr(CSR_COLUMN_INDEX, 16'd0);
      write_csr(CSR_FILTER_MODE, {14'd0, FILTER_SEMI});
      queue_string("e\n", 1'b0);
      queue_string(";a\n", 1'b0);
      queue_string("s", 1'b1);
      wait_idle();

      // held e released by the final byte: three results from one transaction
      write_csr(CSR_FILTER_MODE, {14'd0, FILTER_ES});
      queue_string("ex", 1'b1);
      wait_idle();

      random_start = bytes_queued;
      phase_count  = 0;
      while (bytes_queued - random_start < RANDOM_BYTES) begin
         if (phase_count == 0) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = idle_pick();
            recv_idle_pct = idle_pick();
         end
         pick = $urandom_range(0, 5);
         do_phase(8'($urandom_range(0, 4)), 16'(pick > 3 ? 0 : pick),
                  2'($urandom_range(0, 3)), $urandom_range(1, 2), phase_count == 0);
         phase_count++;
      end

      // closing part without idling, ends in an error that halts the block
      quiet = 1'b1;
      short_branch = 1'($urandom_range(0, 1));
      if (short_branch) begin
         do_phase(8'($urandom_range(0, 2)), 16'd1, 2'($urandom_range(0, 3)), 1, 1'b0);
      end
      write_csr(CSR_COLUMN_INDEX, {8'd0, COLUMNS_MAX});
      write_csr(CSR_SKIP_LINES, LINES_MAX);
      if (!short_branch) write_csr(CSR_SKIP_LINES, 16'd0);
      queue_string("ab cd\n", 1'b0);
      queue_string("xyz", 1'b1);
      repeat (8) queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      wait_idle();

      $display("%0d text bytes in %0d files, %0d register writes, %0d random phases",
               bytes_queued, files_sent, csr_writes, phase_count);
      $display("%0d results checked, closing error: %s", results_seen,
               short_branch ? "file ended during skip" : "missing column");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #((CLOCK_HIGH + CLOCK_LOW) * TIMEOUT_CYCLES);
      $display("simulation failed");
      $finish;
   end

endmodule
